/* hw/rtl/sidta_pkg.sv */
// ----------------------------------------------------------------------------
// sidta_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sidta_pkg;

	localparam int BIN_W      = 32;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int IDX_W      = 4;
	localparam int STEP_W     = 5;
	localparam int CHAR_W     = 6;

	localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(BIN_W - 1);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input word, clear BCD
		logic shift;      // one double-dabble step
		logic init_idx;   // point at most significant non-zero digit
		logic next_digit; // move to next lower digit
		logic sel_sign;   // present minus sign instead of a digit
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic neg;
		logic idx_zero;
	} sts_t;

endpackage

/* hw/rtl/sidta_datapath.sv */
// ----------------------------------------------------------------------------
// sidta_datapath
// Magnitude register, double-dabble BCD converter and character select.
// ----------------------------------------------------------------------------
module sidta_datapath import sidta_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic signed [BIN_W-1:0] value,
	output sts_t                    sts,
	output logic [CHAR_W-1:0]       char_code,
	output logic                    last_char
);

	logic [BIN_W-1:0] mag_q;
	logic [BCD_W-1:0] bcd_q;
	logic             neg_q;
	logic [IDX_W-1:0] idx_q;

	logic [BIN_W-1:0] value_u;
	logic [BCD_W-1:0] bcd_adj;
	logic [3:0]       nib [NUM_DIGITS];
	logic [IDX_W-1:0] idx_init;
	logic [3:0]       cur_digit;

	assign value_u = value;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			nib[i] = bcd_q[4*i +: 4];
			bcd_adj[4*i +: 4] = (nib[i] >= 4'd5) ? nib[i] + 4'd3 : nib[i];
		end
	end

	// highest non-zero digit, digit 0 when the value is zero
	always_comb begin
		idx_init = '0;
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (nib[i] != 4'd0) begin
				idx_init = IDX_W'(i);
			end
		end
	end

	assign cur_digit = nib[idx_q];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= value_u[BIN_W-1] ? (~value_u + BIN_W'(1)) : value_u;
			bcd_q <= '0;
		end else if (cmd.shift) begin
			mag_q <= {mag_q[BIN_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[BIN_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cmd.load) begin
				neg_q <= value_u[BIN_W-1];
			end
			if (cmd.init_idx) begin
				idx_q <= idx_init;
			end else if (cmd.next_digit) begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	assign sts.neg      = neg_q;
	assign sts.idx_zero = (idx_q == '0);

	assign char_code = cmd.sel_sign ? CHAR_MINUS : CHAR_ZERO + {2'b00, cur_digit};
	assign last_char = !cmd.sel_sign && (idx_q == '0);

	// no leading zero once the start digit is chosen
	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.init_idx) && (idx_q != '0) |-> (cur_digit != 4'd0))
		else $error("leading zero digit selected");

	// double-dabble keeps every digit decimal
	a_digit_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.next_digit |-> (cur_digit <= 4'd9))
		else $error("non-decimal digit emitted");

	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (bcd_q == '0))
		else $error("BCD not cleared on load");

endmodule

/* hw/rtl/sidta_ctrl.sv */
// ----------------------------------------------------------------------------
// sidta_ctrl
// Sequencer: conversion steps, then sign and digit characters.
// ----------------------------------------------------------------------------
module sidta_ctrl import sidta_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_PREP,
		S_SIGN,
		S_DIGITS
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_SIGN) || (state_q == S_DIGITS);

	always_comb begin
		cmd.load       = (state_q == S_IDLE) && in_valid;
		cmd.shift      = (state_q == S_CONV);
		cmd.init_idx   = (state_q == S_PREP);
		cmd.sel_sign   = (state_q == S_SIGN);
		cmd.next_digit = (state_q == S_DIGITS) && !out_stall && !sts.idx_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (in_valid) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= sts.neg ? S_SIGN : S_DIGITS;
				end
				S_SIGN: begin
					if (!out_stall) begin
						state_q <= S_DIGITS;
					end
				end
				S_DIGITS: begin
					if (!out_stall && sts.idx_zero) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// conversion always runs the full word width
	a_conv_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV) && (step_q == '0)
		|-> ##31 (state_q == S_CONV) ##1 (state_q == S_PREP))
		else $error("conversion length wrong");

	// final digit taken returns to idle
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGITS) && !out_stall && sts.idx_zero |=> (state_q == S_IDLE))
		else $error("run did not end after last word");

	// sign word only for negative input
	a_sign_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SIGN) |-> sts.neg)
		else $error("minus sign for non-negative value");

endmodule

/* hw/rtl/signed_integer_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_integer_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, MSD first.
// ----------------------------------------------------------------------------
// Conversion: the 32-step bit-serial double-dabble loop, then n = 1..11 output
//   words (sign and digits), one word per cycle while out_stall is low; the
//   next input word is taken only once the last output word is accepted.
// Reset: arst_n clears the sequencer to idle; no output word is pending.
// ----------------------------------------------------------------------------
module signed_integer_to_decimal_ascii import sidta_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [BIN_W-1:0] value,
	// output channel, one word per character
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CHAR_W-1:0]       char_code,
	output logic                    last_char
);

	// Flow:
	//   idle      - input taken when valid; stall is low here, high in all other states
	//   convert   - magnitude shifted MSB first through the BCD register,
	//               one shift-and-correct step per cycle
	//   prepare   - pointer set to the top non-zero digit (digit 0 for zero)
	//   sign      - minus sign word, negative inputs only
	//   digits    - one digit word per accepted cycle, last flagged at digit 0
	// The most negative input needs no special path: its unsigned magnitude
	// fits the 32-bit shift register and ten BCD digits.

	cmd_t cmd;
	sts_t sts;

	sidta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sidta_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (value),
		.sts       (sts),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule
